/* rtl/chts_pkg.sv */
// Package: constants, types and codes shared by the hash table block.
package chts_pkg;
	localparam int MAX_BUCKETS = 64;
	localparam int SLOTS_PER_BUCKET = 8;
	localparam int KEY_W = 31;
	localparam int BC_W = 7;
	localparam int BKT_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
	localparam int SLOT_W = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
	localparam int FILL_W = $clog2(SLOTS_PER_BUCKET + 1);
	localparam int ADDR_W = BKT_W + SLOT_W;
	localparam int DEPTH = MAX_BUCKETS * SLOTS_PER_BUCKET;
	localparam int REM_W = BC_W + 1;

	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_REMOVE = 2'd1;
	localparam logic [1:0] ACT_FIND   = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;

	typedef struct packed {
		logic [1:0]       action;
		logic [KEY_W-1:0] key;
		logic [BKT_W-1:0] bucket;
	} cmd_t;

	typedef enum logic [2:0] {
		FE_IDLE, FE_DIV, FE_PUSH
	} fe_state_t;

	typedef enum logic [3:0] {
		BE_CLEAR, BE_IDLE, BE_FILL, BE_READ, BE_SCAN, BE_SHR_RD, BE_SHR_WR, BE_SHL_RD,
		BE_SHL_WR, BE_DONE
	} be_state_t;
endpackage

/* rtl/chts_front.sv */
// Front end: takes words, computes the bucket by a bit-serial remainder.
module chts_front import chts_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       action,
	input  logic [KEY_W-1:0] key,
	input  logic [BC_W-1:0]  bucket_count,
	output logic             q_push,
	output cmd_t             q_data,
	input  logic             q_full
);
	fe_state_t state_q, state_d;
	logic [1:0]       act_q;
	logic [KEY_W-1:0] key_q;
	logic [KEY_W-1:0] shf_q;
	logic [REM_W-1:0] rem_q;
	logic [4:0]       cnt_q;
	logic [BC_W-1:0]  mod_q;
	logic [BC_W-1:0]  mod_d;
	logic [REM_W-1:0] trial;
	logic             last;

	always_comb begin
		if (bucket_count == '0) mod_d = BC_W'(1);
		else if (32'(bucket_count) > MAX_BUCKETS) mod_d = BC_W'(MAX_BUCKETS);
		else mod_d = bucket_count;
	end

	assign trial = {rem_q[REM_W-2:0], shf_q[KEY_W-1]};
	assign last = (cnt_q == 5'(KEY_W - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FE_IDLE: if (in_valid) state_d = FE_DIV;
			FE_DIV:  if (last) state_d = FE_PUSH;
			FE_PUSH: if (!q_full) state_d = FE_IDLE;
			default: state_d = FE_IDLE;
		endcase
	end

	always_comb begin
		in_stall = (state_q != FE_IDLE);
		q_push = (state_q == FE_PUSH) && !q_full;
		q_data.action = act_q;
		q_data.key = key_q;
		q_data.bucket = rem_q[BKT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= FE_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (state_q == FE_IDLE && in_valid) begin
			act_q <= action;
			key_q <= key;
			shf_q <= key;
			rem_q <= '0;
			cnt_q <= '0;
			mod_q <= mod_d;
		end else if (state_q == FE_DIV) begin
			shf_q <= {shf_q[KEY_W-2:0], 1'b0};
			cnt_q <= cnt_q + 5'd1;
			if (trial >= {1'b0, mod_q}) rem_q <= trial - {1'b0, mod_q};
			else rem_q <= trial;
		end
	end
endmodule

/* rtl/chts_queue.sv */
// Two-entry command queue between the front end and the back end.
module chts_queue import chts_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	output logic full,
	input  logic pop,
	output cmd_t pop_data,
	output logic not_empty
);
	cmd_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign pop_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_data;
	end
endmodule

/* rtl/chts_back.sv */
// Back end: bucket memory, fill counts and the slot walk with shifting.
module chts_back import chts_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  cmd_t       q_data,
	output logic       q_pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       found,
	output logic [1:0] status
);
	be_state_t state_q, state_d;
	logic [KEY_W-1:0] mem [DEPTH];
	logic [KEY_W-1:0] rd_q;
	logic [ADDR_W-1:0] raddr;
	logic              rd_en;
	logic              wr_en;
	logic [ADDR_W-1:0] waddr;
	logic [KEY_W-1:0]  wdata;

	logic [FILL_W-1:0] fill_mem [MAX_BUCKETS];
	logic [FILL_W-1:0] fill_rd_q;
	logic [BKT_W-1:0]  clr_q;
	logic              fill_we;
	logic [BKT_W-1:0]  fill_waddr;
	logic [FILL_W-1:0] fill_wdata;
	cmd_t              cmd_q;
	logic [FILL_W-1:0] n_q;
	logic [FILL_W-1:0] i_q;
	logic [FILL_W-1:0] j_q;
	logic [KEY_W-1:0]  hold_q;
	logic              found_q, ov_q;
	logic [1:0]        status_q;
	logic              scan_end, hit, stop;

	// Scan ends when the walk reaches fill or a key decides the operation.
	always_comb begin
		scan_end = (i_q == n_q);
		hit = 1'b0;
		stop = 1'b0;
		if (!scan_end) begin
			case (cmd_q.action)
				ACT_INSERT: stop = !(cmd_q.key > rd_q);
				ACT_REMOVE: begin hit = (rd_q == cmd_q.key); stop = hit; end
				ACT_FIND: begin
					hit = (rd_q == cmd_q.key);
					stop = hit || (rd_q > cmd_q.key);
				end
				default: stop = 1'b1;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BE_CLEAR: if (clr_q == BKT_W'(MAX_BUCKETS - 1)) state_d = BE_IDLE;
			BE_IDLE: if (q_valid && !ov_q) state_d = BE_FILL;
			BE_FILL: state_d = BE_READ;
			BE_READ: state_d = BE_SCAN;
			BE_SCAN: begin
				if (cmd_q.action == ACT_INSERT && 32'(n_q) >= SLOTS_PER_BUCKET)
					state_d = BE_DONE;
				else if (scan_end || stop) begin
					if (cmd_q.action == ACT_INSERT) state_d = BE_SHR_RD;
					else if (cmd_q.action == ACT_REMOVE && hit) state_d = BE_SHL_RD;
					else state_d = BE_DONE;
				end else state_d = BE_READ;
			end
			BE_SHR_RD: state_d = BE_SHR_WR;
			BE_SHR_WR: state_d = (j_q == i_q) ? BE_DONE : BE_SHR_RD;
			BE_SHL_RD: state_d = (j_q + FILL_W'(1) >= n_q) ? BE_DONE : BE_SHL_WR;
			BE_SHL_WR: state_d = BE_SHL_RD;
			BE_DONE: state_d = BE_IDLE;
			default: state_d = BE_IDLE;
		endcase
	end

	always_comb begin
		q_pop = (state_q == BE_IDLE) && q_valid && !ov_q;
		rd_en = 1'b0;
		raddr = {cmd_q.bucket, i_q[SLOT_W-1:0]};
		wr_en = 1'b0;
		waddr = {cmd_q.bucket, j_q[SLOT_W-1:0]};
		wdata = hold_q;
		fill_we = 1'b0;
		fill_waddr = cmd_q.bucket;
		fill_wdata = n_q + FILL_W'(1);
		unique case (state_q)
			BE_CLEAR: begin
				fill_we = 1'b1;
				fill_waddr = clr_q;
				fill_wdata = '0;
			end
			BE_READ: rd_en = !scan_end;
			BE_SHR_RD: begin
				rd_en = (j_q != i_q);
				raddr = {cmd_q.bucket, SLOT_W'(j_q - FILL_W'(1))};
			end
			BE_SHR_WR: begin
				wr_en = 1'b1;
				wdata = (j_q == i_q) ? cmd_q.key : rd_q;
				fill_we = (j_q == i_q);
			end
			BE_SHL_RD: begin
				rd_en = (j_q + FILL_W'(1) < n_q);
				raddr = {cmd_q.bucket, SLOT_W'(j_q + FILL_W'(1))};
				fill_we = (j_q + FILL_W'(1) >= n_q);
				fill_wdata = n_q - FILL_W'(1);
			end
			BE_SHL_WR: begin wr_en = 1'b1; wdata = rd_q; end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rd_en) rd_q <= mem[raddr];
		if (wr_en) mem[waddr] <= wdata;
	end

	// Fill counts: one read when a command is taken, one write port.
	always_ff @(posedge clk) begin
		if (q_pop) fill_rd_q <= fill_mem[q_data.bucket];
		if (fill_we) fill_mem[fill_waddr] <= fill_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BE_CLEAR;
			ov_q <= 1'b0;
			clr_q <= '0;
		end else begin
			state_q <= state_d;
			if (ov_q && !out_stall) ov_q <= 1'b0;
			if (state_q == BE_DONE) ov_q <= 1'b1;
			if (state_q == BE_CLEAR) clr_q <= clr_q + BKT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			BE_IDLE: if (q_valid && !ov_q) begin
				cmd_q <= q_data;
				i_q <= '0;
				found_q <= 1'b0;
				status_q <= ST_OK;
			end
			BE_FILL: n_q <= (32'(fill_rd_q) > SLOTS_PER_BUCKET)
				? FILL_W'(SLOTS_PER_BUCKET) : fill_rd_q;
			BE_SCAN: begin
				if (cmd_q.action == ACT_INSERT && 32'(n_q) >= SLOTS_PER_BUCKET)
					status_q <= ST_FULL;
				else if (scan_end || stop) begin
					j_q <= (cmd_q.action == ACT_INSERT) ? n_q : i_q;
					found_q <= hit;
					if ((cmd_q.action == ACT_REMOVE || cmd_q.action == ACT_FIND) && !hit)
						status_q <= ST_NOTFOUND;
				end else i_q <= i_q + FILL_W'(1);
			end
			BE_SHR_WR: j_q <= j_q - FILL_W'(1);
			BE_SHL_WR: j_q <= j_q + FILL_W'(1);
			default: ;
		endcase
		hold_q <= rd_q;
	end

	assign out_valid = ov_q;
	assign found = found_q;
	assign status = status_q;
endmodule

/* rtl/chained_hash_table_sorted_buckets_unit.sv */
// Top level of the hash table with sorted fixed-depth buckets.
//  channel | signals                        | direction
//  input   | in_valid in_stall action key   | word in, one per operation
//  output  | out_valid out_stall found status | result word out
//  config  | cfg_valid cfg_ready cfg_data   | bucket_count write
// The front end takes one word at a time: it accepts it, works out a bit-serial
// remainder of the 31-bit key by the bucket count and then queues the command.
// The back end fetches the bucket fill, walks the row slot by slot through a
// one-port memory and shifts slots for insert or remove, a read and a write per slot.
// After reset the back end clears the 64 fill counts; the key memory is not cleared.
// A stalled output holds its word and the back end waits; the queue lets the
// front end keep working meanwhile.
module chained_hash_table_sorted_buckets_unit import chts_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       action,
	input  logic [KEY_W-1:0] key,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             found,
	output logic [1:0]       status,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [BC_W-1:0]  cfg_data
);
	logic [BC_W-1:0] bucket_count_q;
	logic push, full, pop, nonempty;
	cmd_t push_data, pop_data;

	// The register is always writable; the user must make writes only while idle, the block does not enforce it.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) bucket_count_q <= BC_W'(64);
		else if (cfg_valid) bucket_count_q <= cfg_data;
	end

	chts_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .action, .key,
		.bucket_count(bucket_count_q), .q_push(push), .q_data(push_data), .q_full(full)
	);

	chts_queue u_queue (
		.clk, .arst_n, .push, .push_data, .full, .pop, .pop_data, .not_empty(nonempty)
	);

	chts_back u_back (
		.clk, .arst_n, .q_valid(nonempty), .q_data(pop_data), .q_pop(pop),
		.out_valid, .out_stall, .found, .status
	);
endmodule

/* rtl/chts_checker.sv */
// Port checker for the hash table block, with its bind.
module chts_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic       found,
	input logic [1:0] status
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(found) && $stable(status))
		else $error("stalled result changed");
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3)
		else $error("bad status code");
	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> status == 2'd0)
		else $error("found with error status");
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |=> !out_valid)
		else $error("results back to back");
endmodule

bind chained_hash_table_sorted_buckets_unit chts_checker u_chk (
	.clk, .arst_n, .out_valid, .out_stall, .found, .status
);

/* tb/sv/tb_chained_hash_table_sorted_buckets_unit.sv */
// Testbench for the sorted-bucket hash table: random operations checked against a predictor.
`timescale 1ns / 100ps

import chts_pkg::*;

// Scoreboard: keeps a copy of the table and the queue of predicted result words.
class table_scoreboard;
	logic [KEY_W-1:0] slot_key [MAX_BUCKETS][SLOTS_PER_BUCKET];
	int unsigned      slot_fill [MAX_BUCKETS];
	logic [BC_W-1:0]  modulus_reg;
	logic [2:0]       pending_q [$];
	int unsigned      errors;

	function new();
		foreach (slot_fill[b]) slot_fill[b] = 0;
		modulus_reg = 7'd64;
		errors = 0;
	endfunction

	function void set_bucket_count(logic [BC_W-1:0] v);
		modulus_reg = v;
	endfunction

	// Predicts the result of one accepted operation and updates the table copy.
	function void note_input(logic [1:0] act, logic [KEY_W-1:0] k);
		int unsigned m, b, n, i, j;
		logic fnd;
		logic [1:0] st;
		m = modulus_reg;
		if (m == 0) m = 1;
		if (m > MAX_BUCKETS) m = MAX_BUCKETS;
		b = k % m;
		n = slot_fill[b];
		fnd = 1'b0;
		st = ST_OK;
		if (act == ACT_INSERT) begin
			if (n >= SLOTS_PER_BUCKET) begin
				st = ST_FULL;
			end else begin
				i = 0;
				while (i < n && k > slot_key[b][i]) i++;
				for (j = n; j > i; j--) slot_key[b][j] = slot_key[b][j-1];
				slot_key[b][i] = k;
				slot_fill[b] = n + 1;
			end
		end else if (act == ACT_REMOVE) begin
			i = 0;
			while (i < n && slot_key[b][i] != k) i++;
			if (i < n) begin
				for (j = i; j + 1 < n; j++) slot_key[b][j] = slot_key[b][j+1];
				slot_fill[b] = n - 1;
				fnd = 1'b1;
			end else begin
				st = ST_NOTFOUND;
			end
		end else if (act == ACT_FIND) begin
			i = 0;
			while (i < n && slot_key[b][i] <= k) begin
				if (slot_key[b][i] == k) begin
					fnd = 1'b1;
					break;
				end
				i++;
			end
			if (!fnd) st = ST_NOTFOUND;
		end
		pending_q.push_back({fnd, st});
	endfunction

	function void check_result(logic fnd, logic [1:0] st);
		logic [2:0] exp_word;
		if (pending_q.size() == 0) begin
			$display("%0t: result word with nothing expected: found=%0d status=%0d",
				$time, fnd, st);
			errors++;
			return;
		end
		exp_word = pending_q.pop_front();
		if (fnd !== exp_word[2]) begin
			$display("%0t: found mismatch: expected %0d, actual %0d", $time, exp_word[2], fnd);
			errors++;
		end
		if (st !== exp_word[1:0]) begin
			$display("%0t: status mismatch: expected %0d, actual %0d",
				$time, exp_word[1:0], st);
			errors++;
		end
	endfunction
endclass

module tb_chained_hash_table_sorted_buckets_unit;
	// Generous ceiling on the run; the slowest correct run needs a small fraction of it.
	localparam int unsigned CYCLE_LIMIT = 1000000;
	// Settling time after the last result before a register write or the end.
	localparam int unsigned SETTLE_CYCLES = 60;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic [1:0]       action;
	logic [KEY_W-1:0] key;
	logic             out_valid;
	logic             out_stall;
	logic             found;
	logic [1:0]       status;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [BC_W-1:0]  cfg_data;

	table_scoreboard sb;
	int unsigned     cycle_count;
	// When set, neither side idles; gives stretches of back-to-back words.
	logic            no_idle;

	chained_hash_table_sorted_buckets_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.key       (key),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.found     (found),
		.status    (status),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int unsigned pick_gap();
		if (no_idle) return 0;
		if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
		return $urandom_range(5, 40);
	endfunction

	// The run is bounded by a cycle counter; hitting it is a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Input monitor: every accepted word goes to the predictor. Signals are
	// sampled as they stood before the edge, since all drivers use nonblocking
	// assignments.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) sb.note_input(action, key);
	end

	// Output monitor: every accepted result word is checked in order.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_result(found, status);
	end

	// Receiver: the stall is held for random stretches, short ones mostly.
	initial begin
		int unsigned hold;
		out_stall = 1'b0;
		forever begin
			hold = pick_gap();
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	end

	// Sends one word. With no gap the valid stays high and only the payload
	// moves on; with a gap the valid drops for the idle cycles.
	task automatic send_word(input logic [1:0] act, input logic [KEY_W-1:0] k);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action   <= act;
		key      <= k;
		do @(posedge clk); while (in_stall);
	endtask

	// Waits until every predicted word has come back, then lets the block settle.
	// The first edge makes sure the last accepted word has reached the predictor.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes bucket_count; only called while the block is idle.
	task automatic write_bucket_count(input logic [BC_W-1:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_bucket_count(v);
	endtask

	// One random phase: mostly keys from a narrow range so buckets fill up,
	// collide and hold duplicates, with some full-width keys and a few unused codes.
	task automatic random_phase(input logic [BC_W-1:0] cnt, input int unsigned n_words);
		int unsigned span, r;
		logic [1:0] act;
		logic [KEY_W-1:0] k;
		span = (cnt == 0 ? 1 : (cnt > MAX_BUCKETS ? MAX_BUCKETS : cnt)) * 6;
		write_bucket_count(cnt);
		for (int unsigned w = 0; w < n_words; w++) begin
			if (w % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (r < 45) act = ACT_INSERT;
			else if (r < 70) act = ACT_REMOVE;
			else if (r < 97) act = ACT_FIND;
			else act = 2'd3;
			if ($urandom_range(0, 9) < 7) k = KEY_W'($urandom_range(0, span));
			else k = KEY_W'($urandom() & 32'h7FFF_FFFF);
			send_word(act, k);
		end
		no_idle = 1'b0;
	endtask

	initial begin
		sb          = new();
		no_idle     = 1'b0;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		action      = ACT_INSERT;
		key         = '0;
		cfg_valid   = 1'b0;
		cfg_data    = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at reset modulus: extreme keys, all codes, not-found cases.
		send_word(ACT_FIND, '0);
		send_word(ACT_REMOVE, '1);
		send_word(ACT_INSERT, '1);
		send_word(ACT_INSERT, '0);
		send_word(ACT_FIND, '1);
		send_word(2'd3, '1);
		send_word(ACT_REMOVE, '0);

		// Four buckets: fill bucket zero out of order with a duplicate, then overflow it.
		write_bucket_count(7'd4);
		send_word(ACT_INSERT, 31'd28);
		send_word(ACT_INSERT, 31'd8);
		send_word(ACT_INSERT, 31'd16);
		send_word(ACT_INSERT, 31'd8);
		send_word(ACT_INSERT, 31'd0);
		send_word(ACT_INSERT, 31'd40);
		send_word(ACT_INSERT, 31'd4);
		send_word(ACT_INSERT, 31'd12);
		send_word(ACT_INSERT, 31'd20);
		send_word(ACT_FIND, 31'd12);
		send_word(ACT_FIND, 31'd24);
		send_word(ACT_REMOVE, 31'd8);
		send_word(ACT_FIND, 31'd8);
		send_word(ACT_REMOVE, 31'd36);

		// Changing the modulus leaves stored keys in place.
		write_bucket_count(7'd0);
		send_word(ACT_FIND, 31'd16);
		send_word(ACT_INSERT, 31'd5);
		write_bucket_count(7'd127);
		send_word(ACT_FIND, 31'd28);
		send_word(ACT_INSERT, 31'd65);

		random_phase(7'd1, 150);
		random_phase(7'd64, 250);
		random_phase(7'd3, 150);
		random_phase(7'd127, 150);
		random_phase(7'd0, 100);
		random_phase(7'd65, 100);
		random_phase(7'($urandom_range(2, 63)), 150);
		random_phase(7'($urandom_range(0, 127)), 150);

		drain();
		if (sb.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule

/* files.f */
rtl/chts_pkg.sv
rtl/chts_front.sv
rtl/chts_queue.sv
rtl/chts_back.sv
rtl/chained_hash_table_sorted_buckets_unit.sv
rtl/chts_checker.sv
tb/sv/tb_chained_hash_table_sorted_buckets_unit.sv
